// ===== rtl/core/igb_pkg.sv =====
// Package: shared types and constants for the iterated 3x3 Gaussian blur.
package igb_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int ColBits    = $clog2(MaxWidth);
  localparam int RowBits    = $clog2(MaxHeight);
  localparam int AddrBits   = ColBits + RowBits;
  localparam int DimBits    = 9;
  localparam int PixBits    = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_PASSES = 3'd2,
    REG_CENTER = 3'd3,
    REG_EDGE   = 3'd4,
    REG_CORNER = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] pixel;
  } req_t;

  typedef struct packed {
    logic [15:0] read_pixel;
    logic        saturated;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_START,
    ST_FETCH,
    ST_MAC,
    ST_STORE,
    ST_DONE
  } state_t;

  // Effective frame dimension clamped to 1..max.
  function automatic logic [DimBits-1:0] eff_dim(input logic [DimBits-1:0] v,
                                                 input logic [DimBits-1:0] max_v);
    logic [DimBits-1:0] r;
    r = v;
    if (v == '0) r = DimBits'(1);
    else if (v > max_v) r = max_v;
    return r;
  endfunction

endpackage

// ===== rtl/core/igb_mac.sv =====
// Multiply-accumulate unit: one tap product per cycle, round and saturate.
module igb_mac (
  input  logic        clk,
  input  logic        clear,
  input  logic        tap_valid,
  input  logic [15:0] tap_pixel,
  input  logic [15:0] tap_coef,
  output logic [15:0] result,
  output logic        clamped
);

  logic [31:0] prod;
  logic        prod_valid;
  logic [35:0] acc;
  logic [36:0] rounded;
  logic [20:0] shifted;

  always_ff @(posedge clk) begin
    prod       <= tap_pixel * tap_coef;
    prod_valid <= tap_valid;
    if (clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + 36'(prod);
    end
  end

  always_comb begin
    rounded = 37'(acc) + 37'd32768;
    shifted = rounded[36:16];
    clamped = (shifted > 21'd65535);
    result  = clamped ? 16'hFFFF : shifted[15:0];
  end

endmodule

// ===== rtl/core/iterated_gaussian_blur_3x3.sv =====
// Top level: iterated 3x3 Gaussian blur frame store with command interface.
//
// Pixel writes and reads: a request is taken whenever busy is low, and its
// result strobes on result/result_valid in the next cycle (the receiver
// cannot stall). A run request holds busy high while the blur works through
// the frame one output pixel at a time: each pixel fetches its nine taps from
// the single read port of the source store (one tap per cycle) and feeds one
// shared multiply-accumulate. The run's result strobes in the same cycle that
// busy falls.
// Two frame stores ping-pong; each pass reads one and writes the other.
// Border pixels replicate the nearest edge. The saturation flag is sticky
// from the start of a run. No clearing pass: stores are undefined until
// written.
module iterated_gaussian_blur_3x3 (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  igb_pkg::req_t       request,
  output logic                busy,
  output logic                result_valid,
  output igb_pkg::res_t       result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int AW = igb_pkg::AddrBits;
  localparam int CW = igb_pkg::ColBits;
  localparam int RW = igb_pkg::RowBits;
  localparam int DW = igb_pkg::DimBits;

  // configuration registers
  logic [DW-1:0] frame_width, frame_height;
  logic [3:0]    pass_count;
  logic [15:0]   coef_center, coef_edge, coef_corner;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DW'(256);
      frame_height <= DW'(256);
      pass_count   <= 4'd1;
      coef_center  <= 16'd13382;
      coef_edge    <= 16'd8116;
      coef_corner  <= 16'd4922;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        igb_pkg::REG_WIDTH:  frame_width  <= cfg_data[DW-1:0];
        igb_pkg::REG_HEIGHT: frame_height <= cfg_data[DW-1:0];
        igb_pkg::REG_PASSES: pass_count   <= cfg_data[3:0];
        igb_pkg::REG_CENTER: coef_center  <= cfg_data;
        igb_pkg::REG_EDGE:   coef_edge    <= cfg_data;
        igb_pkg::REG_CORNER: coef_corner  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DW-1:0] w_eff, h_eff;
  assign w_eff = igb_pkg::eff_dim(frame_width, DW'(igb_pkg::MaxWidth));
  assign h_eff = igb_pkg::eff_dim(frame_height, DW'(igb_pkg::MaxHeight));

  // frame stores
  logic [15:0] store_a [2**AW];
  logic [15:0] store_b [2**AW];
  logic [15:0] rd_a, rd_b;
  logic          wr_a, wr_b;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_data;

  always_ff @(posedge clk) begin
    if (wr_a) store_a[wr_addr] <= wr_data;
    rd_a <= store_a[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (wr_b) store_b[wr_addr] <= wr_data;
    rd_b <= store_b[rd_addr];
  end

  // control state
  igb_pkg::state_t state, state_next;
  logic          current_is_b, current_is_b_next;
  logic          saturation_seen, saturation_seen_next;
  logic [3:0]    passes_left, passes_left_next;
  logic [RW-1:0] pr, pr_next;
  logic [CW-1:0] pc, pc_next;
  logic [3:0]    tap, tap_next;
  logic          read_pend;
  logic          read_inside;
  logic          read_from_b;
  logic          result_pend;

  // request decode
  logic accept, in_frame;
  assign accept   = start && !busy;
  assign in_frame = (9'(request.row) < h_eff) && (9'(request.col) < w_eff);

  // tap address with replicated border
  logic signed [1:0] dr, dc;
  logic [RW-1:0] tr;
  logic [CW-1:0] tc;
  logic [15:0]   tap_coef;
  always_comb begin
    dr = 2'sd0;
    dc = 2'sd0;
    case (tap)
      4'd0: begin dr = -2'sd1; dc = -2'sd1; end
      4'd1: begin dr = -2'sd1; dc =  2'sd0; end
      4'd2: begin dr = -2'sd1; dc =  2'sd1; end
      4'd3: begin dr =  2'sd0; dc = -2'sd1; end
      4'd4: begin dr =  2'sd0; dc =  2'sd0; end
      4'd5: begin dr =  2'sd0; dc =  2'sd1; end
      4'd6: begin dr =  2'sd1; dc = -2'sd1; end
      4'd7: begin dr =  2'sd1; dc =  2'sd0; end
      4'd8: begin dr =  2'sd1; dc =  2'sd1; end
      default: ;
    endcase
    if (dr == -2'sd1) tr = (pr == '0) ? pr : pr - RW'(1);
    else if (dr == 2'sd1) tr = (9'(pr) + 9'd1 >= h_eff) ? pr : pr + RW'(1);
    else tr = pr;
    if (dc == -2'sd1) tc = (pc == '0) ? pc : pc - CW'(1);
    else if (dc == 2'sd1) tc = (9'(pc) + 9'd1 >= w_eff) ? pc : pc + CW'(1);
    else tc = pc;
    if (dr == 2'sd0 && dc == 2'sd0) tap_coef = coef_center;
    else if (dr == 2'sd0 || dc == 2'sd0) tap_coef = coef_edge;
    else tap_coef = coef_corner;
  end

  // tap pipeline: address -> memory data -> MAC
  logic        fetch_v, data_v;
  logic [15:0] coef_d1, coef_d2;
  logic [15:0] src_pix;
  logic        mac_clear;
  logic [15:0] mac_result;
  logic        mac_clamped;

  assign src_pix = current_is_b ? rd_b : rd_a;

  always_ff @(posedge clk) begin
    coef_d1 <= tap_coef;
    if (rst) begin
      data_v <= 1'b0;
    end else begin
      data_v <= fetch_v;
    end
  end
  assign coef_d2 = coef_d1;

  igb_mac u_mac (
    .clk       (clk),
    .clear     (mac_clear),
    .tap_valid (data_v),
    .tap_pixel (src_pix),
    .tap_coef  (coef_d2),
    .result    (mac_result),
    .clamped   (mac_clamped)
  );

  always_comb begin
    state_next           = state;
    current_is_b_next    = current_is_b;
    saturation_seen_next = saturation_seen;
    passes_left_next     = passes_left;
    pr_next              = pr;
    pc_next              = pc;
    tap_next             = tap;
    fetch_v              = 1'b0;
    mac_clear            = 1'b0;
    wr_a                 = 1'b0;
    wr_b                 = 1'b0;
    wr_addr              = {request.row[RW-1:0], request.col[CW-1:0]};
    wr_data              = request.pixel;
    rd_addr              = {request.row[RW-1:0], request.col[CW-1:0]};
    busy                 = (state != igb_pkg::ST_IDLE);
    case (state)
      igb_pkg::ST_IDLE: begin
        if (accept) begin
          case (request.operation)
            igb_pkg::OP_WRITE: begin
              if (in_frame) begin
                wr_a = !current_is_b;
                wr_b = current_is_b;
              end
            end
            igb_pkg::OP_RUN: begin
              saturation_seen_next = 1'b0;
              passes_left_next     = pass_count;
              state_next           = igb_pkg::ST_PASS_START;
            end
            default: ;
          endcase
        end
      end
      igb_pkg::ST_PASS_START: begin
        pr_next = '0;
        pc_next = '0;
        tap_next = '0;
        mac_clear = 1'b1;
        state_next = (passes_left == 4'd0) ? igb_pkg::ST_DONE : igb_pkg::ST_FETCH;
      end
      igb_pkg::ST_FETCH: begin
        rd_addr = {tr, tc};
        fetch_v = 1'b1;
        tap_next = tap + 4'd1;
        if (tap == 4'd8) state_next = igb_pkg::ST_MAC;
      end
      igb_pkg::ST_MAC: begin
        // wait for the last tap to clear the read, multiply and add stages
        tap_next = tap + 4'd1;
        rd_addr = {tr, tc};
        if (tap == 4'd11) state_next = igb_pkg::ST_STORE;
      end
      igb_pkg::ST_STORE: begin
        wr_addr = {pr, pc};
        wr_data = mac_result;
        wr_a = current_is_b;
        wr_b = !current_is_b;
        if (mac_clamped) saturation_seen_next = 1'b1;
        mac_clear = 1'b1;
        tap_next  = '0;
        state_next = igb_pkg::ST_FETCH;
        if (9'(pc) + 9'd1 >= w_eff) begin
          pc_next = '0;
          if (9'(pr) + 9'd1 >= h_eff) begin
            current_is_b_next = !current_is_b;
            passes_left_next  = passes_left - 4'd1;
            state_next        = igb_pkg::ST_PASS_START;
          end else begin
            pr_next = pr + RW'(1);
          end
        end else begin
          pc_next = pc + CW'(1);
        end
      end
      igb_pkg::ST_DONE: begin
        state_next = igb_pkg::ST_IDLE;
      end
      default: state_next = igb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= igb_pkg::ST_IDLE;
      current_is_b    <= 1'b0;
      saturation_seen <= 1'b0;
      passes_left     <= '0;
      pr              <= '0;
      pc              <= '0;
      tap             <= '0;
      read_pend       <= 1'b0;
      result_pend     <= 1'b0;
    end else begin
      state           <= state_next;
      current_is_b    <= current_is_b_next;
      saturation_seen <= saturation_seen_next;
      passes_left     <= passes_left_next;
      pr              <= pr_next;
      pc              <= pc_next;
      tap             <= tap_next;
      read_pend       <= accept && (request.operation == igb_pkg::OP_READ);
      result_pend     <= (accept && (request.operation != igb_pkg::OP_RUN)) ||
                         (state == igb_pkg::ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    read_inside <= in_frame;
    read_from_b <= current_is_b;
  end

  // result strobe: the cycle after a write/read/no-op is accepted, or when a run finishes
  assign result_valid      = result_pend;
  assign result.saturated  = saturation_seen;
  assign result.read_pixel = (read_pend && read_inside) ? (read_from_b ? rd_b : rd_a)
                                                        : 16'd0;

`ifndef ASSERT_OFF
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    (state == igb_pkg::ST_IDLE) |-> !busy)
    else $error("busy high while idle");
  a_run_result: assert property (@(posedge clk) disable iff (rst)
    (state == igb_pkg::ST_DONE) |=> result_valid)
    else $error("no result after run");
  a_no_write_conflict: assert property (@(posedge clk) disable iff (rst)
    !(wr_a && wr_b))
    else $error("both stores written");
  a_read_strobe: assert property (@(posedge clk) disable iff (rst)
    read_pend |-> result_valid)
    else $error("read without result strobe");
`endif

endmodule

// ===== test/tb_iterated_gaussian_blur_3x3.sv =====
// Testbench for the iterated 3x3 Gaussian blur frame store, checked against its own predictor.
module tb_iterated_gaussian_blur_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  // Kinds of row in the directed table: one request, one register write,
  // or a fill of the whole frame with random pixels.
  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_CFG,
    ROW_FILL
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    igb_pkg::reg_idx_t idx;
    logic [15:0]       data;
    igb_pkg::req_t     rq;
    bit                typed;
    igb_pkg::res_t     want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic start;
  igb_pkg::req_t request;
  logic busy;
  logic result_valid;
  igb_pkg::res_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  iterated_gaussian_blur_3x3 dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: both frame stores, the ping-pong select, the sticky
  // clamp flag and a shadow of every register.
  // ---------------------------------------------------------------------------
  logic [15:0] img_a [0:65535];
  logic [15:0] img_b [0:65535];
  bit          img_on_b;
  bit          clamp_seen;
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [3:0]  passes_reg;
  logic [15:0] w_center;
  logic [15:0] w_edge;
  logic [15:0] w_corner;

  igb_pkg::res_t pending_results [$];
  int   mismatches;
  int   n_items;
  int   burst_left;
  bit   gappy;

  // Frame size in use: zero acts as one, anything above the store size clamps.
  function automatic int frame_w();
    if (width_reg == 0) return 1;
    if (width_reg > igb_pkg::MaxWidth) return igb_pkg::MaxWidth;
    return width_reg;
  endfunction

  function automatic int frame_h();
    if (height_reg == 0) return 1;
    if (height_reg > igb_pkg::MaxHeight) return igb_pkg::MaxHeight;
    return height_reg;
  endfunction

  // One pass from the current store into the other, replicate border.
  function automatic void blur_once();
    int w, h, rr, cc;
    logic [63:0] acc;
    logic [15:0] p, k;
    w = frame_w();
    h = frame_h();
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        acc = '0;
        for (int dr = -1; dr <= 1; dr++) begin
          rr = r + dr;
          if (rr < 0) rr = 0;
          if (rr >= h) rr = h - 1;
          for (int dc = -1; dc <= 1; dc++) begin
            cc = c + dc;
            if (cc < 0) cc = 0;
            if (cc >= w) cc = w - 1;
            p = img_on_b ? img_b[rr * igb_pkg::MaxWidth + cc]
                         : img_a[rr * igb_pkg::MaxWidth + cc];
            if (dr == 0 && dc == 0) k = w_center;
            else if (dr == 0 || dc == 0) k = w_edge;
            else k = w_corner;
            acc += 64'(p) * 64'(k);
          end
        end
        acc = (acc + 64'd32768) >> 16;
        if (acc > 64'd65535) begin
          acc = 64'd65535;
          clamp_seen = 1'b1;
        end
        if (img_on_b) img_a[r * igb_pkg::MaxWidth + c] = acc[15:0];
        else img_b[r * igb_pkg::MaxWidth + c] = acc[15:0];
      end
    end
    img_on_b = !img_on_b;
  endfunction

  // Advance the predictor by one accepted request and return its result.
  function automatic igb_pkg::res_t predict_result(igb_pkg::req_t rq);
    igb_pkg::res_t rs;
    bit    in_frame;
    int    a;
    rs = '0;
    in_frame = (rq.row < frame_h()) && (rq.col < frame_w());
    a = rq.row * igb_pkg::MaxWidth + rq.col;
    case (igb_pkg::op_t'(rq.operation))
      igb_pkg::OP_WRITE: begin
        if (in_frame) begin
          if (img_on_b) img_b[a] = rq.pixel;
          else img_a[a] = rq.pixel;
        end
      end
      igb_pkg::OP_RUN: begin
        clamp_seen = 1'b0;
        for (int i = 0; i < passes_reg; i++) blur_once();
      end
      igb_pkg::OP_READ: begin
        if (in_frame) rs.read_pixel = img_on_b ? img_b[a] : img_a[a];
      end
      default: ;
    endcase
    rs.saturated = clamp_seen;
    return rs;
  endfunction

  function automatic void shadow_write(igb_pkg::reg_idx_t idx, logic [15:0] d);
    case (idx)
      igb_pkg::REG_WIDTH:  width_reg  = d[8:0];
      igb_pkg::REG_HEIGHT: height_reg = d[8:0];
      igb_pkg::REG_PASSES: passes_reg = d[3:0];
      igb_pkg::REG_CENTER: w_center   = d;
      igb_pkg::REG_EDGE:   w_edge     = d;
      igb_pkg::REG_CORNER: w_corner   = d;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe is matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    igb_pkg::res_t exp_rs;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing outstanding: expected none, got pixel %h sat %b",
                 $time, result.read_pixel, result.saturated);
      end else begin
        exp_rs = pending_results.pop_front();
        if (result.read_pixel !== exp_rs.read_pixel) begin
          mismatches++;
          $display("%0t: read_pixel expected %h, got %h", $time, exp_rs.read_pixel,
                   result.read_pixel);
        end
        if (result.saturated !== exp_rs.saturated) begin
          mismatches++;
          $display("%0t: saturated expected %b, got %b", $time, exp_rs.saturated,
                   result.saturated);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Bursts of back-to-back requests separated by random gaps; some phases run
  // with no gaps at all.
  task automatic pace();
    if (burst_left == 0) begin
      if (gappy) idle_cycles($urandom_range(1, 6));
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  // Present a request; it is taken at the first edge where busy is low.
  task automatic send(igb_pkg::req_t rq, bit typed, igb_pkg::res_t want);
    igb_pkg::res_t pred;
    @(negedge clk);
    start   <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    pred = predict_result(rq);
    pending_results.push_back(typed ? want : pred);
    n_items++;
  endtask

  task automatic send_req(igb_pkg::op_t op, int r, int c, int pix);
    igb_pkg::req_t rq;
    rq.operation = op;
    rq.row       = r[7:0];
    rq.col       = c[7:0];
    rq.pixel     = pix[15:0];
    pace();
    send(rq, 1'b0, '0);
  endtask

  // Hold off until every outstanding result has come back.
  task automatic drain();
    idle_cycles(1);
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic reg_write(igb_pkg::reg_idx_t idx, logic [15:0] d);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    shadow_write(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write every pixel of the frame so runs and reads never touch stale data.
  task automatic fill_frame();
    for (int r = 0; r < frame_h(); r++)
      for (int c = 0; c < frame_w(); c++)
        send_req(igb_pkg::OP_WRITE, r, c, $urandom_range(0, 65535));
  endtask

  function automatic plan_row_t mk(row_kind_t kind, igb_pkg::reg_idx_t idx, int data,
                                   igb_pkg::op_t op, int r, int c, int pix, bit typed,
                                   int rp, bit sat);
    plan_row_t pr;
    pr.kind             = kind;
    pr.idx              = idx;
    pr.data             = data[15:0];
    pr.rq.operation     = op;
    pr.rq.row           = r[7:0];
    pr.rq.col           = c[7:0];
    pr.rq.pixel         = pix[15:0];
    pr.typed            = typed;
    pr.want.read_pixel  = rp[15:0];
    pr.want.saturated   = sat;
    return pr;
  endfunction

  function automatic logic [15:0] pick_weight(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 65535));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(2000, 16000));
    endcase
  endfunction

  plan_row_t plan [$];

  initial begin
    int sz, n, pick, wv, hv;
    start      = 1'b0;
    request    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    mismatches = 0;
    n_items    = 0;
    burst_left = 0;
    gappy      = 1'b1;
    img_on_b   = 1'b0;
    clamp_seen = 1'b0;
    width_reg  = 9'd256;
    height_reg = 9'd256;
    passes_reg = 4'd1;
    w_center   = 16'd13382;
    w_edge     = 16'd8116;
    w_corner   = 16'd4922;

    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Rows with a typed result can be read straight off the
    // behaviour; the rest go through the predictor.
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_NONE,
                      0, 0, 0, 1, 0, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_WRITE,
                      0, 0, 0, 1, 0, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_WRITE,
                      255, 255, 65535, 1, 0, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_READ,
                      255, 255, 0, 1, 65535, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_READ,
                      0, 0, 0, 1, 0, 0));
    // 4 x 1 frame; zero height acts as one row
    plan.push_back(mk(ROW_CFG, igb_pkg::REG_WIDTH, 4, igb_pkg::OP_NONE,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_CFG, igb_pkg::REG_HEIGHT, 0, igb_pkg::OP_NONE,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_FILL, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_NONE,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_READ,
                      0, 3, 0, 0, 0, 0));
    // out of frame: write dropped, read gives zero
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_WRITE,
                      1, 0, 1234, 1, 0, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_READ,
                      0, 4, 0, 1, 0, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_RUN,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_READ,
                      0, 0, 0, 0, 0, 0));
    // all weights at full scale: the sums clamp
    plan.push_back(mk(ROW_CFG, igb_pkg::REG_CENTER, 65535, igb_pkg::OP_NONE,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_CFG, igb_pkg::REG_EDGE, 65535, igb_pkg::OP_NONE,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_CFG, igb_pkg::REG_CORNER, 65535, igb_pkg::OP_NONE,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_WRITE,
                      0, 1, 65535, 0, 0, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_RUN,
                      0, 0, 0, 0, 0, 0));
    // zero passes only clears the sticky flag
    plan.push_back(mk(ROW_CFG, igb_pkg::REG_PASSES, 0, igb_pkg::OP_NONE,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_RUN,
                      0, 0, 0, 1, 0, 0));
    // widest frame, oversize width clamps to the store, most passes
    plan.push_back(mk(ROW_CFG, igb_pkg::REG_CENTER, 0, igb_pkg::OP_NONE,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_CFG, igb_pkg::REG_WIDTH, 511, igb_pkg::OP_NONE,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_CFG, igb_pkg::REG_PASSES, 15, igb_pkg::OP_NONE,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_FILL, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_NONE,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_RUN,
                      0, 0, 0, 0, 0, 0));
    plan.push_back(mk(ROW_REQ, igb_pkg::REG_WIDTH, 0, igb_pkg::OP_READ,
                      0, 255, 0, 0, 0, 0));

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG:  reg_write(plan[i].idx, plan[i].data);
        ROW_FILL: fill_frame();
        default: begin
          pace();
          send(plan[i].rq, plan[i].typed, plan[i].want);
        end
      endcase
    end

    // Random phases: new settings, a full fill, then a mix of requests.
    while (n_items < 1650) begin
      drain();   // sender waits for every outstanding result
      gappy = ($urandom_range(0, 3) != 0);
      sz = $urandom_range(0, 9);
      case (sz)
        0: begin wv = 256; hv = $urandom_range(1, 2); end
        1: begin wv = $urandom_range(0, 1); hv = 256; end
        2: begin wv = $urandom_range(257, 511); hv = $urandom_range(0, 1); end
        default: begin wv = $urandom_range(0, 6); hv = $urandom_range(0, 6); end
      endcase
      reg_write(igb_pkg::REG_WIDTH, 16'(wv));
      reg_write(igb_pkg::REG_HEIGHT, 16'(hv));
      if (sz < 3) reg_write(igb_pkg::REG_PASSES, 16'($urandom_range(0, 2)));
      else if ($urandom_range(0, 9) == 0) reg_write(igb_pkg::REG_PASSES, 16'd15);
      else reg_write(igb_pkg::REG_PASSES, 16'($urandom_range(0, 3)));
      pick = $urandom_range(0, 3);
      reg_write(igb_pkg::REG_CENTER, pick_weight(pick));
      reg_write(igb_pkg::REG_EDGE, pick_weight(pick));
      reg_write(igb_pkg::REG_CORNER, pick_weight(pick));
      fill_frame();
      n = $urandom_range(20, 60);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)
          send_req(igb_pkg::OP_WRITE, $urandom_range(0, frame_h() - 1),
                   $urandom_range(0, frame_w() - 1), $urandom_range(0, 65535));
        else if (pick < 80)
          send_req(igb_pkg::OP_READ, $urandom_range(0, frame_h() - 1),
                   $urandom_range(0, frame_w() - 1), $urandom_range(0, 65535));
        else if (pick < 88)
          send_req(igb_pkg::OP_RUN, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 65535));
        else if (pick < 95)
          send_req(igb_pkg::OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 65535));
        else
          send_req($urandom_range(0, 1) ? igb_pkg::OP_WRITE : igb_pkg::OP_READ,
                   $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 65535));
      end
    end

    drain();
    idle_cycles(20);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/igb_pkg.sv
rtl/core/igb_mac.sv
rtl/core/iterated_gaussian_blur_3x3.sv
test/tb_iterated_gaussian_blur_3x3.sv
